// ===== rtl/ucsps_pkg.sv =====
// Package for the serial-commanded servo pulse sequencer.
// Holds widths, reset values, character codes and the register map.
// No dependencies; every other file imports it.
`timescale 1ns / 1ps

package ucsps_pkg;

  // channel count and field widths
  localparam int NUM_CHANNELS = 4;
  localparam int CH_W         = 2;
  localparam int PINS_W       = 4;
  localparam int WIDTH_W      = 13;
  localparam int CNT_W        = 14;
  localparam int MIN_W        = 12;
  localparam int STEP_W       = 6;
  localparam int GAP_W        = 12;
  localparam int VAL_W        = 7;
  localparam int POS_W        = 3;
  localparam int BYTE_W       = 8;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 12;

  // limits and reset values
  localparam logic [VAL_W-1:0]   VALUE_MAX   = 7'd99;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX   = 13'd8191;
  localparam logic [WIDTH_W-1:0] RESET_WIDTH = 13'd1400;
  localparam logic [MIN_W-1:0]   RESET_MIN   = 12'd900;
  localparam logic [STEP_W-1:0]  RESET_STEP  = 6'd10;
  localparam logic [GAP_W-1:0]   RESET_GAP   = 12'd500;

  // character codes
  localparam logic [BYTE_W-1:0] CHAR_X  = 8'h58;
  localparam logic [BYTE_W-1:0] CHAR_Y  = 8'h59;
  localparam logic [BYTE_W-1:0] CHAR_W  = 8'h57;
  localparam logic [BYTE_W-1:0] CHAR_Z  = 8'h5A;
  localparam logic [BYTE_W-1:0] CHAR_NL = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_0  = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_9  = 8'h39;

  // item kind
  typedef enum logic {
    FUNC_TICK = 1'b0,
    FUNC_BYTE = 1'b1
  } func_e;

  // configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_WIDTH  = 2'd0,
    CFG_WIDTH_STEP = 2'd1,
    CFG_GAP_BASE   = 2'd2
  } cfg_idx_e;

  // width write from the command parser to the pulse timer
  typedef struct packed {
    logic               we;
    logic [CH_W-1:0]    ch;
    logic [WIDTH_W-1:0] width;
  } width_wr_t;

  // result of decoding a command letter
  typedef struct packed {
    logic            hit;
    logic [CH_W-1:0] ch;
  } letter_ch_t;

  function automatic letter_ch_t letter_to_channel(input logic [BYTE_W-1:0] c);
    letter_ch_t r;
    r = '0;
    unique case (c)
      CHAR_X:  begin r.hit = 1'b1; r.ch = 2'd0; end
      CHAR_Y:  begin r.hit = 1'b1; r.ch = 2'd1; end
      CHAR_W:  begin r.hit = 1'b1; r.ch = 2'd2; end
      CHAR_Z:  begin r.hit = 1'b1; r.ch = 2'd3; end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/ucsps_in_if.sv =====
// Request channel carrying one tick or one received byte.
// Depends on ucsps_pkg for field widths.
`timescale 1ns / 1ps

interface ucsps_in_if;
  import ucsps_pkg::*;

  logic              valid;
  logic              ready;
  logic              func;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output func, output rx_byte, input ready);
  modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

// ===== rtl/ucsps_out_if.sv =====
// Result channel carrying the servo levels after each request.
// Depends on ucsps_pkg for field widths.
`timescale 1ns / 1ps

interface ucsps_out_if;
  import ucsps_pkg::*;

  logic              valid;
  logic              ready;
  logic [PINS_W-1:0] servo_pins;
  logic [CH_W-1:0]   active_channel;
  logic              width_updated;

  modport source (output valid, output servo_pins, output active_channel,
                  output width_updated, input ready);
  modport sink   (input valid, input servo_pins, input active_channel,
                  input width_updated, output ready);
endinterface

// ===== rtl/uart_commanded_servo_pulse_sequencer_top.sv =====
// Top level of the serial-commanded servo pulse sequencer.
// Depends on ucsps_pkg, ucsps_in_if, ucsps_out_if, ucsps_cmd_parser, ucsps_pulse_timer.
//
//   channel   dir  signals                                   accepted when
//   in_if     in   func, rx_byte                             valid && ready
//   out_if    out  servo_pins, active_channel, width_updated valid && ready
//   cfg       in   cfg_we_i, cfg_index_i, cfg_data_i         cfg_we_i high
//
// One request per cycle sustained while results are taken; each request passes
// the input register, then the result register, before its result is presented.
// The input register refills while the result register holds a result
// nobody has taken; both stall together only when both are full.
// Reset clears both valid flags and the pulse level, puts widths at 1400 and registers at their defaults.
`timescale 1ns / 1ps

module uart_commanded_servo_pulse_sequencer_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  ucsps_in_if.sink                         in_if,
  ucsps_out_if.source                      out_if,
  input  logic                             cfg_we_i,
  input  logic [ucsps_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ucsps_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import ucsps_pkg::*;

  logic [MIN_W-1:0]  min_width_q;
  logic [STEP_W-1:0] width_step_q;
  logic [GAP_W-1:0]  gap_base_q;

  logic              s1_valid_q;
  logic              s1_func_q;
  logic [BYTE_W-1:0] s1_byte_q;

  logic              out_valid_q;
  logic [PINS_W-1:0] pins_q;
  logic [CH_W-1:0]   chan_q;
  logic              upd_q;

  logic              out_free;
  logic              advance;
  logic              in_ready;
  width_wr_t         wr;
  logic [PINS_W-1:0] pins_nxt;
  logic [CH_W-1:0]   chan_nxt;

  // handshake control
  assign out_free = !out_valid_q || out_if.ready;
  assign advance  = s1_valid_q && out_free;
  assign in_ready = !s1_valid_q || out_free;
  assign in_if.ready = in_ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_width_q  <= RESET_MIN;
      width_step_q <= RESET_STEP;
      gap_base_q   <= RESET_GAP;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MIN_WIDTH:  min_width_q  <= cfg_data_i[MIN_W-1:0];
        CFG_WIDTH_STEP: width_step_q <= cfg_data_i[STEP_W-1:0];
        CFG_GAP_BASE:   gap_base_q   <= cfg_data_i[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_if.valid) begin
      s1_func_q <= in_if.func;
      s1_byte_q <= in_if.rx_byte;
    end
  end

  // command parsing
  ucsps_cmd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (advance && (s1_func_q == FUNC_BYTE)),
    .byte_i       (s1_byte_q),
    .min_width_i  (min_width_q),
    .width_step_i (width_step_q),
    .wr_o         (wr)
  );

  // slot timing
  ucsps_pulse_timer u_timer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .tick_i     (advance && (s1_func_q == FUNC_TICK)),
    .wr_i       (wr),
    .gap_base_i (gap_base_q),
    .pins_o     (pins_nxt),
    .chan_o     (chan_nxt)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pins_q <= pins_nxt;
      chan_q <= chan_nxt;
      upd_q  <= wr.we;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.servo_pins     = pins_q;
  assign out_if.active_channel = chan_q;
  assign out_if.width_updated  = upd_q;

  // a new result always comes from a held request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_q && !$past(out_valid_q)) |-> $past(s1_valid_q))
    else $error("result without request");

endmodule

// ===== rtl/ucsps_cmd_parser.sv =====
// Command line parser: letter, decimal digits, newline -> width write.
// Depends on ucsps_pkg (character codes, width_wr_t).
`timescale 1ns / 1ps

module ucsps_cmd_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         byte_valid_i,
  input  logic [ucsps_pkg::BYTE_W-1:0] byte_i,
  input  logic [ucsps_pkg::MIN_W-1:0]  min_width_i,
  input  logic [ucsps_pkg::STEP_W-1:0] width_step_i,
  output ucsps_pkg::width_wr_t         wr_o
);
  import ucsps_pkg::*;

  logic [BYTE_W-1:0] letter_q, letter_d;
  logic [VAL_W-1:0]  acc_q, acc_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic              ended_q, ended_d;

  letter_ch_t        lc;
  logic [WIDTH_W-1:0] prod;
  logic [CNT_W-1:0]   sum;
  logic [9:0]         acc_next;
  logic [3:0]         digit;
  logic               is_digit;

  // width arithmetic: min + value * step, clipped to 13 bits
  assign lc       = letter_to_channel(letter_q);
  assign prod     = WIDTH_W'(acc_q) * WIDTH_W'(width_step_i);
  assign sum      = CNT_W'(min_width_i) + CNT_W'(prod);
  assign digit    = 4'(byte_i - CHAR_0);
  assign is_digit = (byte_i >= CHAR_0) && (byte_i <= CHAR_9);
  assign acc_next = 10'(acc_q) * 10'd10 + 10'(digit);

  // parser state update
  always_comb begin
    letter_d = letter_q;
    acc_d    = acc_q;
    pos_d    = pos_q;
    ended_d  = ended_q;
    wr_o     = '0;
    if (byte_valid_i) begin
      if (byte_i == CHAR_NL) begin
        if ((pos_q != '0) && lc.hit) begin
          wr_o.we    = 1'b1;
          wr_o.ch    = lc.ch;
          wr_o.width = (sum > CNT_W'(WIDTH_MAX)) ? WIDTH_MAX : sum[WIDTH_W-1:0];
        end
        pos_d   = '0;
        acc_d   = '0;
        ended_d = 1'b0;
      end else begin
        if (pos_q == '0) begin
          letter_d = byte_i;
          acc_d    = '0;
          ended_d  = 1'b0;
        end else if (!ended_q && is_digit) begin
          acc_d = (acc_next > 10'(VALUE_MAX)) ? VALUE_MAX : acc_next[VAL_W-1:0];
        end else begin
          ended_d = 1'b1;
        end
        pos_d = pos_q + 1'b1;
      end
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      letter_q <= '0;
      acc_q    <= '0;
      pos_q    <= '0;
      ended_q  <= 1'b0;
    end else begin
      letter_q <= letter_d;
      acc_q    <= acc_d;
      pos_q    <= pos_d;
      ended_q  <= ended_d;
    end
  end

  // accumulated value never exceeds the clip point
  assert property (@(posedge clk_i) disable iff (!rst_ni) acc_q <= VALUE_MAX)
    else $error("command value above clip point");

endmodule

// ===== rtl/ucsps_pulse_timer.sv =====
// Slot timer: countdown, channel rotation and the per-channel width table.
// Depends on ucsps_pkg (widths, width_wr_t).
`timescale 1ns / 1ps

module ucsps_pulse_timer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         tick_i,
  input  ucsps_pkg::width_wr_t         wr_i,
  input  logic [ucsps_pkg::GAP_W-1:0]  gap_base_i,
  output logic [ucsps_pkg::PINS_W-1:0] pins_o,
  output logic [ucsps_pkg::CH_W-1:0]   chan_o
);
  import ucsps_pkg::*;

  logic [WIDTH_W-1:0] widths_q [NUM_CHANNELS];
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [CH_W-1:0]    chan_q, chan_d;
  logic               high_q, high_d;
  logic [WIDTH_W-1:0] cur_width;

  assign cur_width = widths_q[chan_q];

  // countdown and slot event
  always_comb begin
    cnt_d  = cnt_q;
    chan_d = chan_q;
    high_d = high_q;
    if (tick_i) begin
      if (cnt_q > CNT_W'(1)) begin
        cnt_d = cnt_q - 1'b1;
      end else begin
        high_d = !high_q;
        if (!high_q) begin
          cnt_d = CNT_W'(cur_width);
        end else begin
          cnt_d  = CNT_W'(gap_base_i) + CNT_W'(cur_width);
          chan_d = (chan_q == CH_W'(NUM_CHANNELS - 1)) ? '0 : chan_q + 1'b1;
        end
      end
    end
  end

  // levels after this request
  assign pins_o = high_d ? (PINS_W'(1) << chan_d) : '0;
  assign chan_o = chan_d;

  // timer state and width table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= CNT_W'(1);
      chan_q <= '0;
      high_q <= 1'b0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        widths_q[i] <= RESET_WIDTH;
      end
    end else begin
      cnt_q  <= cnt_d;
      chan_q <= chan_d;
      high_q <= high_d;
      if (wr_i.we) begin
        widths_q[wr_i.ch] <= wr_i.width;
      end
    end
  end

  // channel advances only when its pulse ends
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   !$stable(chan_q) |-> $fell(high_q))
    else $error("channel moved without pulse end");

  // width writes never coincide with ticks
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(tick_i && wr_i.we))
    else $error("width write during tick");

endmodule
